// ===== hw/rtl/mspd_pkg.sv =====
package mspd_pkg;

    // Widths of the configuration port.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_MAX = 4'd3;

    // Reset value of the duty clamp, the PWM timer period.
    localparam logic [14:0] PWM_MAX_RESET = 15'd7199;

    // Bridge drive codes.
    typedef enum logic [1:0] {
        DIR_STOP     = 2'd0,
        DIR_FORWARD  = 2'd1,
        DIR_BACKWARD = 2'd2
    } dir_t;

    // Controller settings as seen by the datapath.
    typedef struct packed {
        logic signed [15:0] kp_gain;
        logic signed [15:0] ki_gain;
        logic signed [15:0] kd_gain;
        logic        [14:0] pwm_max;
    } pid_cfg_t;

endpackage

// ===== hw/rtl/mspd_cfg_regs.sv =====
module mspd_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mspd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mspd_pkg::CFG_DATA_W-1:0] cfg_data,
    output mspd_pkg::pid_cfg_t              cfg
);
    import mspd_pkg::*;

    pid_cfg_t cfg_reg;

    // Register file; writes to an unknown index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain <= '0;
            cfg_reg.ki_gain <= '0;
            cfg_reg.kd_gain <= '0;
            cfg_reg.pwm_max <= PWM_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KP_GAIN: cfg_reg.kp_gain <= $signed(cfg_data);
                REG_KI_GAIN: cfg_reg.ki_gain <= $signed(cfg_data);
                REG_KD_GAIN: cfg_reg.kd_gain <= $signed(cfg_data);
                REG_PWM_MAX: cfg_reg.pwm_max <= cfg_data[14:0];
                default:     ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/mspd_pid_core.sv =====
module mspd_pid_core (
    input  logic                clk,
    input  logic                rst_n,
    input  mspd_pkg::pid_cfg_t  cfg,
    input  logic                step_en,
    input  logic signed [15:0]  desired_speed,
    input  logic signed [15:0]  measured_speed,
    output logic [14:0]         duty,
    output mspd_pkg::dir_t      dir
);
    import mspd_pkg::*;

    logic signed [31:0] error_sum_reg;
    logic signed [31:0] error_sum_next;
    logic signed [16:0] last_error_reg;
    logic        [14:0] last_duty_reg;

    logic signed [16:0] des_ext;
    logic signed [16:0] mea_ext;
    logic signed [16:0] abs_des;
    logic signed [16:0] abs_mea;
    logic signed [16:0] err;
    logic signed [17:0] diff;
    logic signed [32:0] sum_wide;
    logic signed [32:0] p_kp;
    logic signed [47:0] p_ki;
    logic signed [33:0] p_kd;
    logic signed [49:0] acc;
    logic signed [41:0] quot;
    logic signed [15:0] term;
    logic signed [17:0] duty_sum;
    logic signed [17:0] duty_lim;

    // Error is the difference of the two magnitudes.
    assign des_ext = 17'(desired_speed);
    assign mea_ext = 17'(measured_speed);
    assign abs_des = des_ext[16] ? -des_ext : des_ext;
    assign abs_mea = mea_ext[16] ? -mea_ext : mea_ext;
    assign err     = abs_des - abs_mea;
    assign diff    = 18'(err) - 18'(last_error_reg);

    // Running sum of errors, saturated to 32 bits.
    assign sum_wide = 33'(error_sum_reg) + 33'(err);
    always_comb
    begin
        if (sum_wide > 33'sd2147483647)
            error_sum_next = 32'sh7FFF_FFFF;
        else if (sum_wide < -33'sd2147483648)
            error_sum_next = 32'sh8000_0000;
        else
            error_sum_next = sum_wide[31:0];
    end

    // The three gain products and their exact sum.
    assign p_kp = cfg.kp_gain * err;
    assign p_ki = cfg.ki_gain * error_sum_next;
    assign p_kd = cfg.kd_gain * diff;
    assign acc  = 50'(p_kp) + 50'(p_ki) + 50'(p_kd);

    // Drop the fraction toward zero: a negative sum with fraction bits set
    // moves up by one after the arithmetic shift.
    assign quot = $signed(acc[49:8]) + $signed({41'd0, acc[49] & (|acc[7:0])});

    // Saturate the PID term to 16 bits.
    always_comb
    begin
        if (quot > 42'sd32767)
            term = 16'sh7FFF;
        else if (quot < -42'sd32768)
            term = 16'sh8000;
        else
            term = quot[15:0];
    end

    // New duty, clamped to the range of the PWM timer.
    assign duty_sum = 18'(term) + $signed({3'd0, last_duty_reg});
    always_comb
    begin
        if (duty_sum > $signed({3'd0, cfg.pwm_max}))
            duty_lim = $signed({3'd0, cfg.pwm_max});
        else if (duty_sum <= 18'sd0)
            duty_lim = '0;
        else
            duty_lim = duty_sum;
    end
    assign duty = duty_lim[14:0];

    // Direction follows the sign of the desired speed.
    always_comb
    begin
        if (desired_speed[15])
            dir = DIR_BACKWARD;
        else if (desired_speed != 16'sd0)
            dir = DIR_FORWARD;
        else
            dir = DIR_STOP;
    end

    // Controller state moves on once per word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            last_duty_reg  <= '0;
        end
        else if (step_en)
        begin
            error_sum_reg  <= error_sum_next;
            last_error_reg <= err;
            last_duty_reg  <= duty;
        end
    end

    // State only moves on a step.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(error_sum_reg) && $stable(last_error_reg)
                     && $stable(last_duty_reg))
        else $error("controller state changed without a step");

    // The stored duty is what the previous step produced.
    a_duty_track: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> last_duty_reg == $past(duty))
        else $error("stored duty differs from the emitted duty");

endmodule

// ===== hw/rtl/motor_speed_pid_with_direction.sv =====
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  desired_speed, measured_speed
// output    out        out_valid/out_stall pwm_duty, direction
// config    in         cfg_we             cfg_index, cfg_data
//
// One word is accepted per cycle unless in_stall is high. An accepted word goes into the input
// register, then through the PID datapath into the result register once that register frees up.
// The datapath cycle is set by the 16x32 integral multiply and the sum after it.
// Reset clears the controller state, the gains and both valid flags; the duty
// clamp resets to the timer period.
// A stalled result holds the datapath; the input register still takes one word.
module motor_speed_pid_with_direction (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [15:0]              desired_speed,
    input  logic signed [15:0]              measured_speed,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [14:0]                     pwm_duty,
    output logic [1:0]                      direction,
    input  logic                            cfg_we,
    input  logic [mspd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mspd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mspd_pkg::*;

    pid_cfg_t           cfg;
    logic               in_valid_reg;
    logic signed [15:0] des_reg;
    logic signed [15:0] mea_reg;
    logic               out_valid_reg;
    logic [14:0]        duty_reg;
    dir_t               dir_reg;
    logic               advance;
    logic               in_take;
    logic [14:0]        duty_calc;
    dir_t               dir_calc;

    // A held word moves into the result register when that register frees up.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    mspd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mspd_pid_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .step_en        (advance),
        .desired_speed  (des_reg),
        .measured_speed (mea_reg),
        .duty           (duty_calc),
        .dir            (dir_calc)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            des_reg <= desired_speed;
            mea_reg <= measured_speed;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            duty_reg <= duty_calc;
            dir_reg  <= dir_calc;
        end
    end

    assign out_valid = out_valid_reg;
    assign pwm_duty  = duty_reg;
    assign direction = dir_reg;

    // A step always leaves a result waiting.
    a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("step did not load the result register");

    // An accepted word is held in the input register.
    a_take_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted word was lost");

    // A stalled result is not overwritten by a step.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !advance)
        else $error("step while the result is stalled");

endmodule
